[hdl/counter_hash_gaussian_noise_assert.svh]
// Assertion macros used by the noise source RTL.
`ifndef COUNTER_HASH_GAUSSIAN_NOISE_ASSERT_SVH
`define COUNTER_HASH_GAUSSIAN_NOISE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CHG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/chg_pkg.sv]
`default_nettype none

package chg_pkg;

    // Hash rounds and the odd multiplier used on the low word.
    localparam int HASH_ROUNDS = 10;
    localparam logic [31:0] MUL_LO = 32'h9E3779B9;

    // Iteration counts of the log and square-root pipelines.
    localparam int LOG_ITERS  = 28;
    localparam int SQRT_ITERS = 32;
    localparam int NEST_STEPS = 6;

    // Fixed-point constants in Q.30.
    localparam logic [30:0] K2LN2_Q30   = 31'd1488522236;
    localparam logic [30:0] KHALFPI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // Stage counts of the two arms; the phase arm is delayed to match.
    localparam int RADIUS_DEPTH = 3 + LOG_ITERS + 2 + SQRT_ITERS;
    localparam int PHASE_DEPTH  = 3 + 3 * NEST_STEPS + 1;
    localparam int PHASE_DELAY  = RADIUS_DEPTH - PHASE_DEPTH;

    typedef logic [7:0] div_t;

    // Taylor series divisors in nested order and floor(2^32 / k).
    localparam div_t COS_DIV [NEST_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] COS_RECIP [NEST_STEPS] = '{
        32'd32537631, 32'd47721858, 32'd76695844,
        32'd143165576, 32'd357913941, 32'd2147483648};
    localparam div_t SIN_DIV [NEST_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] SIN_RECIP [NEST_STEPS] = '{
        32'd27531841, 32'd39045157, 32'd59652323,
        32'd102261126, 32'd214748364, 32'd715827882};

    // Radius arm result.
    typedef struct packed {
        logic        valid;
        logic [31:0] root;
    } radius_out_t;

    // Phase arm result: trig magnitude in Q.30 and its sign.
    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [30:0] mag;
    } phase_out_t;

    // Low word of the round key MUL_LO * round.
    function automatic logic [31:0] round_key(input int unsigned rnd);
        logic [63:0] prod;
        prod = {32'd0, MUL_LO} * 64'(rnd);
        return prod[31:0];
    endfunction

endpackage

`default_nettype wire

[hdl/chg_radius.sv]
`default_nettype none

module chg_radius (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [31:0]         in_bits,
    output chg_pkg::radius_out_t     out
);
    import chg_pkg::*;

    // Front stages: increment, leading-one search, normalization.
    logic        s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic [32:0] s0_m_reg, s1_m_reg;
    logic [5:0]  s1_e_reg, s2_e_reg;
    logic [31:0] s2_f_reg;
    logic [5:0]  e_next;
    logic [31:0] f_next;
    logic [63:0] f_wide;

    // Leading one of m; m is never zero.
    always_comb
    begin
        e_next = 6'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (s0_m_reg[i])
            begin
                e_next = 6'(i);
            end
        end
    end

    // Bring the top set bit to bit 31 (Q1.31 mantissa).
    always_comb
    begin
        f_wide = {31'd0, s1_m_reg} << (6'd31 - s1_e_reg);
        if (s1_e_reg == 6'd32)
        begin
            f_next = s1_m_reg[32:1];
        end
        else
        begin
            f_next = f_wide[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_m_reg <= {1'b0, in_bits} + 33'd1;
            s1_m_reg <= s0_m_reg;
            s1_e_reg <= e_next;
            s2_e_reg <= s1_e_reg;
            s2_f_reg <= f_next;
        end
    end

    // Fraction of log2 by repeated squaring, one bit per stage.
    logic        lg_valid_reg [LOG_ITERS];
    logic [31:0] lg_f_reg     [LOG_ITERS];
    logic [27:0] lg_frac_reg  [LOG_ITERS];
    logic [5:0]  lg_e_reg     [LOG_ITERS];

    for (genvar i = 0; i < LOG_ITERS; i++)
    begin : g_log
        logic        v_prev;
        logic [31:0] f_prev;
        logic [27:0] frac_prev;
        logic [5:0]  e_prev;
        logic [63:0] sq;
        logic [31:0] f_step;
        logic [27:0] frac_step;

        if (i == 0)
        begin : g_first
            assign v_prev    = s2_valid_reg;
            assign f_prev    = s2_f_reg;
            assign frac_prev = 28'd0;
            assign e_prev    = s2_e_reg;
        end
        else
        begin : g_rest
            assign v_prev    = lg_valid_reg[i-1];
            assign f_prev    = lg_f_reg[i-1];
            assign frac_prev = lg_frac_reg[i-1];
            assign e_prev    = lg_e_reg[i-1];
        end

        // Square, and renormalize when the square reaches two.
        always_comb
        begin
            sq        = {32'd0, f_prev} * {32'd0, f_prev};
            frac_step = frac_prev;
            if (sq[63])
            begin
                f_step            = sq[63:32];
                frac_step[27 - i] = 1'b1;
            end
            else
            begin
                f_step = sq[62:31];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lg_valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                lg_valid_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lg_f_reg[i]    <= f_step;
                lg_frac_reg[i] <= frac_step;
                lg_e_reg[i]    <= e_prev;
            end
        end
    end

    // L = 32 - log2(m) in Q.28, then S = L * 2 ln 2.
    logic        l_valid_reg, s_valid_reg;
    logic [33:0] l_reg;
    logic [33:0] s_reg;
    logic [64:0] s_prod;

    assign s_prod = 65'(l_reg) * 65'(K2LN2_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            l_valid_reg <= lg_valid_reg[LOG_ITERS-1];
            s_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg <= (34'(6'd32 - lg_e_reg[LOG_ITERS-1]) << 28)
                     - 34'(lg_frac_reg[LOG_ITERS-1]);
            s_reg <= s_prod[63:30];
        end
    end

    // Restoring square root of S * 2^28, one root bit per stage.
    logic        sq_valid_reg [SQRT_ITERS];
    logic [61:0] sq_n_reg     [SQRT_ITERS];
    logic [62:0] sq_res_reg   [SQRT_ITERS];

    for (genvar k = 0; k < SQRT_ITERS; k++)
    begin : g_sqrt
        localparam logic [62:0] SQ_BIT = 63'd1 << (62 - 2 * k);
        logic        v_prev;
        logic [61:0] n_prev;
        logic [62:0] res_prev;
        logic [63:0] trial;
        logic [61:0] n_step;
        logic [62:0] res_step;

        if (k == 0)
        begin : g_first
            assign v_prev   = s_valid_reg;
            assign n_prev   = {s_reg, 28'd0};
            assign res_prev = 63'd0;
        end
        else
        begin : g_rest
            assign v_prev   = sq_valid_reg[k-1];
            assign n_prev   = sq_n_reg[k-1];
            assign res_prev = sq_res_reg[k-1];
        end

        always_comb
        begin
            trial = 64'(res_prev) + 64'(SQ_BIT);
            if (64'(n_prev) >= trial)
            begin
                n_step   = n_prev - trial[61:0];
                res_step = (res_prev >> 1) + SQ_BIT;
            end
            else
            begin
                n_step   = n_prev;
                res_step = res_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[k]   <= n_step;
                sq_res_reg[k] <= res_step;
            end
        end
    end

    assign out.valid = sq_valid_reg[SQRT_ITERS-1];
    assign out.root  = sq_res_reg[SQRT_ITERS-1][31:0];

endmodule

`default_nettype wire

[hdl/chg_phase.sv]
`default_nettype none

module chg_phase (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [31:0]        in_bits,
    output chg_pkg::phase_out_t     out
);
    import chg_pkg::*;

    localparam int NEST_STAGES = 3 * NEST_STEPS;

    // Front: phase, angle a in Q.30, and a squared.
    logic        t0_valid_reg, t1_valid_reg, t2_valid_reg;
    logic [1:0]  t0_quad_reg, t1_quad_reg, t2_quad_reg;
    logic [60:0] t0_qmul_reg;
    logic [30:0] t1_a_reg, t2_a_reg;
    logic [31:0] t2_a2_reg;
    logic [31:0] phase;
    logic [61:0] a_sq;

    assign phase = in_bits + 32'd1;
    assign a_sq  = {31'd0, t1_a_reg} * {31'd0, t1_a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t0_valid_reg <= in_valid;
            t1_valid_reg <= t0_valid_reg;
            t2_valid_reg <= t1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_quad_reg <= phase[31:30];
            t0_qmul_reg <= {31'd0, phase[29:0]} * {30'd0, KHALFPI_Q30};
            t1_quad_reg <= t0_quad_reg;
            t1_a_reg    <= t0_qmul_reg[60:30];
            t2_quad_reg <= t1_quad_reg;
            t2_a_reg    <= t1_a_reg;
            t2_a2_reg   <= a_sq[61:30];
        end
    end

    // Side data carried through every nested-series stage.
    logic        c_valid_reg [NEST_STAGES];
    logic [1:0]  c_quad_reg  [NEST_STAGES];
    logic [30:0] c_a_reg     [NEST_STAGES];
    logic [31:0] c_a2_reg    [NEST_STAGES];

    for (genvar s = 0; s < NEST_STAGES; s++)
    begin : g_carry
        logic        v_prev;
        logic [1:0]  quad_prev;
        logic [30:0] a_prev;
        logic [31:0] a2_prev;

        if (s == 0)
        begin : g_first
            assign v_prev    = t2_valid_reg;
            assign quad_prev = t2_quad_reg;
            assign a_prev    = t2_a_reg;
            assign a2_prev   = t2_a2_reg;
        end
        else
        begin : g_rest
            assign v_prev    = c_valid_reg[s-1];
            assign quad_prev = c_quad_reg[s-1];
            assign a_prev    = c_a_reg[s-1];
            assign a2_prev   = c_a2_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                c_valid_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_quad_reg[s] <= quad_prev;
                c_a_reg[s]    <= a_prev;
                c_a2_reg[s]   <= a2_prev;
            end
        end
    end

    // Nested series step t = 1 - (a2 * t / k), in three stages:
    // product, reciprocal estimate, remainder correction.
    logic [31:0]        na_p_reg [NEST_STEPS];
    logic [31:0]        nb_p_reg [NEST_STEPS];
    logic [31:0]        nb_q_reg [NEST_STEPS];
    logic signed [31:0] nc_t_reg [NEST_STEPS];

    for (genvar j = 0; j < NEST_STEPS; j++)
    begin : g_nest
        logic [30:0] t_prev;
        logic [31:0] a2_in;
        logic [62:0] p_prod;
        logic [63:0] q_prod;
        logic        is_sin_b, is_sin_c;
        logic [31:0] recip;
        div_t        divisor;
        logic [39:0] rem;
        logic [31:0] q_fix;

        if (j == 0)
        begin : g_first
            assign t_prev = ONE_Q30;
            assign a2_in  = t2_a2_reg;
        end
        else
        begin : g_rest
            assign t_prev = nc_t_reg[j-1][30:0];
            assign a2_in  = c_a2_reg[3*j-1];
        end

        // Sine steps run in quadrants one and three.
        assign is_sin_b = c_quad_reg[3*j][0];
        assign is_sin_c = c_quad_reg[3*j+1][0];
        assign recip    = is_sin_b ? SIN_RECIP[j] : COS_RECIP[j];
        assign divisor  = is_sin_c ? SIN_DIV[j] : COS_DIV[j];

        assign p_prod = {31'd0, a2_in} * {32'd0, t_prev};
        assign q_prod = {32'd0, na_p_reg[j]} * {32'd0, recip};

        // The estimate is low by at most one.
        always_comb
        begin
            rem   = 40'(nb_p_reg[j]) - 40'(nb_q_reg[j]) * 40'(divisor);
            q_fix = nb_q_reg[j];
            if (rem >= 40'(divisor))
            begin
                q_fix = nb_q_reg[j] + 32'd1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                na_p_reg[j] <= p_prod[61:30];
                nb_p_reg[j] <= na_p_reg[j];
                nb_q_reg[j] <= q_prod[63:32];
                nc_t_reg[j] <= signed'({1'b0, ONE_Q30}) - signed'(q_fix);
            end
        end
    end

    // Final: clamp the cosine, or scale the sine series by a.
    logic               f_valid_reg;
    logic               f_neg_reg;
    logic [30:0]        f_mag_reg;
    logic signed [31:0] t_last;
    logic [1:0]         quad_last;
    logic [61:0]        sin_prod;
    logic [30:0]        mag_next;

    assign t_last    = nc_t_reg[NEST_STEPS-1];
    assign quad_last = c_quad_reg[NEST_STAGES-1];
    assign sin_prod  = {31'd0, c_a_reg[NEST_STAGES-1]} * {31'd0, t_last[30:0]};

    always_comb
    begin
        if (quad_last[0])
        begin
            mag_next = sin_prod[60:30];
        end
        else if (t_last < 0)
        begin
            mag_next = 31'd0;
        end
        else
        begin
            mag_next = t_last[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= c_valid_reg[NEST_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_neg_reg <= quad_last[1] ^ quad_last[0];
            f_mag_reg <= mag_next;
        end
    end

    assign out.valid = f_valid_reg;
    assign out.neg   = f_neg_reg;
    assign out.mag   = f_mag_reg;

endmodule

`default_nettype wire

[hdl/counter_hash_gaussian_noise.sv]
// Counter-based Gaussian noise source.
// Slave side: one beat per 64-bit counter on s_tdata. Master side: one beat per
// counter, a signed Q3.12 Gaussian sample on m_tdata, in the order accepted.
// The counter and its successor are hashed in a 10-stage multiplier pipeline;
// the first hash feeds a log and square-root arm (65 stages: 28 squaring
// stages for the logarithm, 32 root-bit stages), the second a sine/cosine arm
// (22 stages) that is delayed to line up. Two stages scale, round and saturate.
// Throughput is one beat per clock while s_tready is high; most stages hold a
// single multiplier or one wide add and compare.
// A skid register behind the output register lets the pipeline take one more
// beat while the master side stalls; once the skid is full, s_tready drops and
// the whole pipeline holds, losing and repeating nothing.
// Reset clears all valid bits; no beat is in flight afterwards.
`default_nettype none

module counter_hash_gaussian_noise (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] counter
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [15:0] sample
);
    import chg_pkg::*;

    logic adv;
    logic out_take;

    // Hash pipeline: only the low word matters, one round per stage.
    logic        hash_valid_reg [HASH_ROUNDS];
    logic [31:0] hash_a_reg     [HASH_ROUNDS];
    logic [31:0] hash_b_reg     [HASH_ROUNDS];

    for (genvar i = 0; i < HASH_ROUNDS; i++)
    begin : g_hash
        localparam logic [31:0] KEY = round_key(i + 1);
        logic        v_prev;
        logic [31:0] a_prev, b_prev;
        logic [63:0] a_prod, b_prod;

        if (i == 0)
        begin : g_first
            assign v_prev = s_tvalid;
            assign a_prev = s_tdata[31:0];
            assign b_prev = s_tdata[31:0] + 32'd1;
        end
        else
        begin : g_rest
            assign v_prev = hash_valid_reg[i-1];
            assign a_prev = hash_a_reg[i-1];
            assign b_prev = hash_b_reg[i-1];
        end

        assign a_prod = {32'd0, a_prev} * {32'd0, MUL_LO};
        assign b_prod = {32'd0, b_prev} * {32'd0, MUL_LO};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hash_valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                hash_valid_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hash_a_reg[i] <= a_prod[31:0] ^ KEY;
                hash_b_reg[i] <= b_prod[31:0] ^ KEY;
            end
        end
    end

    // Radius and phase arms.
    radius_out_t rad_out;
    phase_out_t  ph_out;

    chg_radius u_radius (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (hash_valid_reg[HASH_ROUNDS-1]),
        .in_bits  (hash_a_reg[HASH_ROUNDS-1]),
        .out      (rad_out)
    );

    chg_phase u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (hash_valid_reg[HASH_ROUNDS-1]),
        .in_bits  (hash_b_reg[HASH_ROUNDS-1]),
        .out      (ph_out)
    );

    // Delay line that aligns the phase arm with the radius arm.
    logic        dly_valid_reg [PHASE_DELAY];
    logic        dly_neg_reg   [PHASE_DELAY];
    logic [30:0] dly_mag_reg   [PHASE_DELAY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PHASE_DELAY; i++)
            begin
                dly_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            dly_valid_reg[0] <= ph_out.valid;
            for (int i = 1; i < PHASE_DELAY; i++)
            begin
                dly_valid_reg[i] <= dly_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_neg_reg[0] <= ph_out.neg;
            dly_mag_reg[0] <= ph_out.mag;
            for (int i = 1; i < PHASE_DELAY; i++)
            begin
                dly_neg_reg[i] <= dly_neg_reg[i-1];
                dly_mag_reg[i] <= dly_mag_reg[i-1];
            end
        end
    end

    // Scale the radius by the trig magnitude, then round and saturate.
    logic        f1_valid_reg, f2_valid_reg;
    logic        f1_neg_reg;
    logic [62:0] f1_prod_reg;
    logic [15:0] f2_sample_reg;
    logic [63:0] rounded;
    logic [17:0] q12;
    logic [17:0] q12_neg;
    logic [15:0] sample_next;

    assign rounded = 64'(f1_prod_reg) + (64'd1 << 45);
    assign q12     = rounded[63:46];
    assign q12_neg = 18'd0 - q12;

    always_comb
    begin
        if (f1_neg_reg)
        begin
            sample_next = (q12 > 18'd32768) ? 16'h8000 : q12_neg[15:0];
        end
        else
        begin
            sample_next = (q12 > 18'd32767) ? 16'h7FFF : q12[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= rad_out.valid & dly_valid_reg[PHASE_DELAY-1];
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_neg_reg    <= dly_neg_reg[PHASE_DELAY-1];
            f1_prod_reg   <= {31'd0, rad_out.root} * {32'd0, dly_mag_reg[PHASE_DELAY-1]};
            f2_sample_reg <= sample_next;
        end
    end

    // Output register with a skid register behind it.
    logic        m_tvalid_reg, m_tvalid_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [15:0] m_tdata_reg, skid_data_reg;

    assign adv      = !skid_valid_reg;
    assign out_take = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        m_tvalid_next   = m_tvalid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_take)
        begin
            m_tvalid_next   = skid_valid_reg | f2_valid_reg;
            skid_valid_next = 1'b0;
        end
        else if (adv && f2_valid_reg)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg   <= m_tvalid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            m_tdata_reg <= skid_valid_reg ? skid_data_reg : f2_sample_reg;
        end
        else if (adv)
        begin
            skid_data_reg <= f2_sample_reg;
        end
    end

    // Checks on the arm alignment and the skid register.
    `include "counter_hash_gaussian_noise_assert.svh"

    `CHG_ASSERT_NOW(a_arms_aligned, 1'b1, rad_out.valid == dly_valid_reg[PHASE_DELAY-1], "radius and phase arms out of step")
    `CHG_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_tvalid_reg, "skid holds a beat while the output register is empty")
    `CHG_ASSERT_NEXT(a_skid_drains, out_take, !skid_valid_reg, "skid register not drained when the output moved")

endmodule

`default_nettype wire

[tb/sv/counter_hash_gaussian_noise_checker.sv]
`default_nettype none

module counter_hash_gaussian_noise_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] HI_MULT = 32'hBB67AE85;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    logic [15:0] sample_queue[$];

    // Ten rounds of the counter hash; only the low word is kept.
    function automatic logic [31:0] hash_word(input logic [63:0] word);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] key;
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            lo = 32'(64'(word[31:0]) * 64'(chg_pkg::MUL_LO));
            hi = 32'(64'(word[63:32]) * 64'(HI_MULT));
            key = 64'(chg_pkg::MUL_LO) * 64'(rnd);
            word = {hi, lo} ^ key;
        end
        return word[31:0];
    endfunction

    // 32 - log2(m) in Q.28, mantissa squared repeatedly in Q1.31.
    function automatic logic [63:0] neg_log_q28(input logic [63:0] m);
        int e;
        logic [63:0] f;
        logic [63:0] frac;
        e = 0;
        frac = 0;
        while (e < 32 && (m >> (e + 1)) != 0)
            e++;
        f = (e <= 31) ? (m << (31 - e)) : (m >> 1);
        for (int i = 0; i < 28; i++)
        begin
            f = (f * f) >> 31;
            if (f >= (64'd1 << 32))
            begin
                f = f >> 1;
                frac[27 - i] = 1'b1;
            end
        end
        return (64'(32 - e) << 28) - frac;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Trig magnitude in Q.30 for a phase in turns; sign through neg.
    function automatic logic [63:0] trig_q30(input logic [31:0] phase, output logic neg);
        logic [1:0] quad;
        logic [63:0] a;
        logic [63:0] a2;
        logic signed [63:0] t;
        logic [63:0] p;
        quad = phase[31:30];
        a = (64'(phase[29:0]) * 64'(chg_pkg::KHALFPI_Q30)) >> 30;
        a2 = (a * a) >> 30;
        t = Q30_ONE;
        neg = (quad == 2'd1 || quad == 2'd2);
        for (int k = 0; k < chg_pkg::NEST_STEPS; k++)
        begin
            p = (a2 * 64'(t)) >> 30;
            p = p / ((quad[0] == 1'b0) ? 64'(chg_pkg::COS_DIV[k]) : 64'(chg_pkg::SIN_DIV[k]));
            t = $signed(Q30_ONE) - $signed(p);
        end
        if (quad[0] == 1'b0)
            return (t < 0) ? 64'd0 : 64'(t);
        return (a * 64'(t)) >> 30;
    endfunction

    function automatic logic [15:0] gaussian_sample(input logic [63:0] counter);
        logic [31:0] b1;
        logic [31:0] b2;
        logic [63:0] radius;
        logic [63:0] mag;
        logic [63:0] q12;
        logic neg;
        b1 = hash_word(counter);
        b2 = hash_word(counter + 64'd1);
        radius = int_root(((neg_log_q28(64'(b1) + 64'd1)
            * 64'(chg_pkg::K2LN2_Q30)) >> 30) << 28);
        mag = trig_q30(b2 + 32'd1, neg);
        q12 = (radius * mag + (64'd1 << 45)) >> 46;
        if (neg)
            return (q12 > 64'd32768) ? 16'h8000 : 16'(-q12);
        return (q12 > 64'd32767) ? 16'h7FFF : 16'(q12);
    endfunction

    // Predict on each accepted counter, compare on each sample beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors <= 0;
            sample_queue.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (sample_queue.size() == 0)
                begin
                    $error("unexpected sample beat %h", m_tdata);
                    errors <= errors + 1;
                end
                else if (sample_queue[0] != m_tdata)
                begin
                    $error("sample: expected %0d, actual %0d",
                        $signed(sample_queue[0]), $signed(m_tdata));
                    errors <= errors + 1;
                    void'(sample_queue.pop_front());
                end
                else
                    void'(sample_queue.pop_front());
            end
            if (s_tvalid && s_tready)
                sample_queue.push_back(gaussian_sample(s_tdata));
        end
    end

    assign pending = sample_queue.size();

endmodule

`default_nettype wire

[tb/sv/counter_hash_gaussian_noise_test.sv]
`default_nettype none

module counter_hash_gaussian_noise_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    int          errors;
    int          pending;
    bit          long_hold = 1'b0;
    int          cycles = 0;

    always #6 clk = ~clk;

    counter_hash_gaussian_noise dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    counter_hash_gaussian_noise_checker sample_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    initial
    begin
        int mode;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
                m_tready <= 1'b0;
            else
            begin
                mode = (cycles / 500) % 3;
                if (mode == 0)
                    m_tready <= 1'b1;
                else if (mode == 1)
                    m_tready <= ($urandom_range(0, 3) != 0);
                else
                    m_tready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    // Present one counter and hold it until accepted; valid stays high
    // so that the next beat can follow without a gap.
    task automatic send_counter(input logic [63:0] counter);
        s_tvalid <= 1'b1;
        s_tdata <= counter;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid before the sender goes quiet.
    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] directed[$];
        int burst;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, wrap of the successor, alternating and single-bit patterns.
        directed = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
            64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
            64'hFFFF_FFFF_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        foreach (directed[i])
            send_counter(directed[i]);
        for (int i = 0; i < 12; i++)
            send_counter(64'd1 << (i * 5 + 3));

        // Sender pauses until every sample has come back.
        stop_sending();
        wait_drained();

        // Long receiver hold-off while the sender keeps offering beats.
        long_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 150; i++)
                send_counter({$urandom, $urandom});
        join

        // Random bursts with random gaps; some runs of consecutive counters.
        for (int n = 0; n < 1430; n += burst)
        begin
            logic [63:0] base;
            burst = $urandom_range(1, 40);
            base = {$urandom, $urandom};
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 1) != 0)
                    send_counter(base + 64'(i));
                else
                    send_counter({$urandom, $urandom});
            end
            if ($urandom_range(0, 2) == 0)
            begin
                stop_sending();
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end

        stop_sending();
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/chg_pkg.sv
hdl/chg_radius.sv
hdl/chg_phase.sv
hdl/counter_hash_gaussian_noise.sv
tb/sv/counter_hash_gaussian_noise_checker.sv
tb/sv/counter_hash_gaussian_noise_test.sv
